/* sv/srm_pkg.sv */
// Shared types, sizes, request codes and helper functions of the sorted run merge block.
package srm_pkg;

	localparam int RUN_CAPACITY = 32;
	localparam int VALUE_BITS   = 32;
	localparam int ITEM_BITS    = 32;
	localparam int IDX_W        = (RUN_CAPACITY > 1) ? $clog2(RUN_CAPACITY) : 1;
	localparam int CNT_W        = $clog2(RUN_CAPACITY + 1);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [ITEM_BITS-1:0]  item_t;
	typedef logic [CNT_W-1:0]      count_t;
	typedef logic [IDX_W-1:0]      idx_t;

	localparam count_t CAP_COUNT = count_t'(RUN_CAPACITY);

	localparam logic [1:0] REQ_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] REQ_LOAD_SECOND = 2'd1;
	localparam logic [1:0] REQ_MERGE       = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD_FIRST,
		OP_LOAD_SECOND,
		OP_MERGE
	} op_t;

	typedef struct packed {
		op_t    op;
		value_t value;
	} cmd_t;

	function automatic value_t to_value(input item_t x);
		return VALUE_BITS'(x);
	endfunction

	function automatic item_t to_item(input value_t v);
		return ITEM_BITS'(v);
	endfunction

	// Signed order is an unsigned compare with the sign bits flipped.
	function automatic logic value_less(input value_t a, input value_t b, input logic signed_mode);
		value_t sa;
		value_t sb;
		sa = a;
		sb = b;
		if (signed_mode) begin
			sa[VALUE_BITS-1] = ~a[VALUE_BITS-1];
			sb[VALUE_BITS-1] = ~b[VALUE_BITS-1];
		end
		return sa < sb;
	endfunction

endpackage

/* sv/srm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module srm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* sv/srm_front.sv */
// Front end: accepts requests, turns them into commands and queues them for the back end.
module srm_front import srm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  item_t      item_value,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	cmd_t              q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              is_cmd;
	cmd_t              new_cmd;
	logic              push;
	logic              pop;

	always_comb begin
		is_cmd        = 1'b1;
		new_cmd.op    = OP_MERGE;
		new_cmd.value = to_value(item_value);
		case (req_type)
			REQ_LOAD_FIRST:  new_cmd.op = OP_LOAD_FIRST;
			REQ_LOAD_SECOND: new_cmd.op = OP_LOAD_SECOND;
			REQ_MERGE:       new_cmd.op = OP_MERGE;
			default:         is_cmd = 1'b0;
		endcase
	end

	assign in_ready  = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];
	// Unknown request codes are accepted and discarded here.
	assign push      = in_valid && in_ready && is_cmd;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* sv/srm_back.sv */
// Back end: executes queued loads into the run stores and runs the merge sequencer.
module srm_back import srm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_ready,
	input  cmd_t  cmd,
	input  logic  order_mode,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t merged_value,
	output logic  from_second,
	output logic  last_flag,
	output logic  empty_flag,
	output logic  overflow_flag
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	state_t state_q;
	count_t cnt1_q;
	count_t cnt2_q;
	count_t i_q;
	count_t j_q;
	logic   sticky_q;

	logic   cmd_fire;
	logic   we1;
	logic   we2;
	value_t rd1;
	value_t rd2;
	logic   take_second;
	count_t i_nx;
	count_t j_nx;
	logic   is_last;
	logic   out_free;
	logic   emit;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign we1       = cmd_fire && (cmd.op == OP_LOAD_FIRST) && (cnt1_q < CAP_COUNT);
	assign we2       = cmd_fire && (cmd.op == OP_LOAD_SECOND) && (cnt2_q < CAP_COUNT);
	assign out_free  = !out_valid || out_ready;
	assign emit      = ((state_q == ST_EMIT) || (state_q == ST_EMPTY)) && out_free;

	srm_ram #(.WIDTH(VALUE_BITS), .DEPTH(RUN_CAPACITY)) u_first_ram (
		.clk     (clk),
		.wr_en   (we1),
		.wr_addr (cnt1_q[IDX_W-1:0]),
		.wr_data (cmd.value),
		.rd_addr (i_q[IDX_W-1:0]),
		.rd_data (rd1)
	);

	srm_ram #(.WIDTH(VALUE_BITS), .DEPTH(RUN_CAPACITY)) u_second_ram (
		.clk     (clk),
		.wr_en   (we2),
		.wr_addr (cnt2_q[IDX_W-1:0]),
		.wr_data (cmd.value),
		.rd_addr (j_q[IDX_W-1:0]),
		.rd_data (rd2)
	);

	// On equal values the first run wins, so only a strict less-than picks the second run.
	always_comb begin
		if (i_q == cnt1_q) begin
			take_second = 1'b1;
		end else if (j_q == cnt2_q) begin
			take_second = 1'b0;
		end else begin
			take_second = value_less(rd2, rd1, order_mode);
		end
		i_nx    = take_second ? i_q : i_q + 1'b1;
		j_nx    = take_second ? j_q + 1'b1 : j_q;
		is_last = (i_nx == cnt1_q) && (j_nx == cnt2_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt1_q        <= '0;
			cnt2_q        <= '0;
			i_q           <= '0;
			j_q           <= '0;
			sticky_q      <= 1'b0;
			out_valid     <= 1'b0;
			merged_value  <= '0;
			from_second   <= 1'b0;
			last_flag     <= 1'b0;
			empty_flag    <= 1'b0;
			overflow_flag <= 1'b0;
		end else begin
			out_valid <= emit || (out_valid && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.op)
							OP_LOAD_FIRST: begin
								if (cnt1_q < CAP_COUNT) begin
									cnt1_q <= cnt1_q + 1'b1;
								end else begin
									sticky_q <= 1'b1;
								end
							end
							OP_LOAD_SECOND: begin
								if (cnt2_q < CAP_COUNT) begin
									cnt2_q <= cnt2_q + 1'b1;
								end else begin
									sticky_q <= 1'b1;
								end
							end
							OP_MERGE: begin
								i_q <= '0;
								j_q <= '0;
								if (cnt1_q == '0 && cnt2_q == '0) begin
									state_q <= ST_EMPTY;
								end else begin
									state_q <= ST_READ;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						merged_value  <= to_item(take_second ? rd2 : rd1);
						from_second   <= take_second;
						last_flag     <= is_last;
						empty_flag    <= 1'b0;
						overflow_flag <= sticky_q;
						i_q           <= i_nx;
						j_q           <= j_nx;
						if (is_last) begin
							cnt1_q   <= '0;
							cnt2_q   <= '0;
							sticky_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						merged_value  <= '0;
						from_second   <= 1'b0;
						last_flag     <= 1'b1;
						empty_flag    <= 1'b1;
						overflow_flag <= sticky_q;
						sticky_q      <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/sorted_run_merge.sv */
// Top level of the sorted run merge block: request queue, merge engine and mode register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------------
//   request  | in_valid / in_ready  | req_type, item_value
//   result   | out_valid/ out_ready | merged_value, from_second, last_flag, empty_flag,
//            |                      | overflow_flag
//   config   | cfg_valid/ cfg_ready | cfg_data (order_mode)
//
// Requests enter a two-entry command queue at up to one per cycle while it is not full;
// the engine takes loads while idle, and a merge holds it until its last result is
// issued. Each result has a read state for the registered run store read, then an emit
// state that compares and issues it. An empty merge has an empty state for its single
// result. A stalled result holds the engine; the queue keeps taking requests until it
// fills. Reset clears counts, flags, queue and mode; the stores need no clearing pass.
module sorted_run_merge import srm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  item_t      item_value,
	output logic       out_valid,
	input  logic       out_ready,
	output item_t      merged_value,
	output logic       from_second,
	output logic       last_flag,
	output logic       empty_flag,
	output logic       overflow_flag,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	logic order_mode_q;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			order_mode_q <= cfg_data;
		end
	end

	srm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.item_value (item_value),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	srm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.order_mode    (order_mode_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.merged_value  (merged_value),
		.from_second   (from_second),
		.last_flag     (last_flag),
		.empty_flag    (empty_flag),
		.overflow_flag (overflow_flag)
	);

endmodule

/* sv/srm_checker.sv */
// Port-level checker for the sorted run merge block and its bind to the top level.
module srm_checker import srm_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  out_valid,
	input logic  out_ready,
	input item_t merged_value,
	input logic  from_second,
	input logic  last_flag,
	input logic  empty_flag,
	input logic  overflow_flag
);

	logic mid_merge;
	assign mid_merge = out_valid && out_ready && !last_flag;

	// A stalled result transaction keeps its payload; overflow_flag is not checked here.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(merged_value)
			&& $stable(from_second) && $stable(last_flag) && $stable(empty_flag))
		else $error("result payload changed while stalled");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_flag |-> last_flag && !from_second && merged_value == '0)
		else $error("empty result is not a lone zero result");

	// Once a merge has started, no empty marker can appear before its last result.
	a_no_empty_mid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_merge |=> !(out_valid && empty_flag))
		else $error("empty result inside a merge");

	a_overflow_steady: assert property (@(posedge clk) disable iff (!arst_n)
		mid_merge |=> !out_valid || overflow_flag == $past(overflow_flag))
		else $error("overflow flag changed within one merge");

endmodule

bind sorted_run_merge srm_checker u_srm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.merged_value  (merged_value),
	.from_second   (from_second),
	.last_flag     (last_flag),
	.empty_flag    (empty_flag),
	.overflow_flag (overflow_flag)
);
